### rtl/mtseed_pkg.sv
// Shared types, constants and a helper function for the MT19937 state seeding block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mtseed_pkg;

  localparam int TABLE_WORDS_DEF = 624;
  localparam int KEY_WORDS_DEF   = 4;
  localparam int WORD_W          = 32;
  localparam int ADDR_W          = 10;
  localparam int KEY_REGS        = 4;
  localparam int KEY_IDX_W       = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int MODE_W          = 2;

  localparam logic [WORD_W-1:0] MULT_INIT   = 32'd1812433253;
  localparam logic [WORD_W-1:0] MULT_MIX1   = 32'd1664525;
  localparam logic [WORD_W-1:0] MULT_MIX2   = 32'd1566083941;
  localparam logic [WORD_W-1:0] SEED_KEY    = 32'd19650218;
  localparam logic [WORD_W-1:0] WORD0_FINAL = 32'h8000_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEED_VALUE = 2'd0,
    MODE_SEED_KEY   = 2'd1,
    MODE_READ       = 2'd2,
    MODE_NOP        = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_MIX1,
    PH_MIX2
  } phase_t;

  typedef enum logic [2:0] {
    WSRC_P,
    WSRC_INIT,
    WSRC_MIX1,
    WSRC_MIX2,
    WSRC_FINAL
  } wsrc_t;

  typedef logic [KEY_REGS-1:0][WORD_W-1:0] key_array_t;

  // Commands from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic   p_load_seed;
    logic   p_load_key;
    logic   p_upd;
    logic   idx_zero;
    logic   idx_one;
    logic   idx_inc;
    logic   step_clr;
    logic   step_inc;
    logic   key_clr;
    logic   key_inc;
    logic   mul_en;
    phase_t phase;
    logic   rd_en;
    logic   rd_ext;
    logic   wr_en;
    logic   wr_zero;
    wsrc_t  wsrc;
    logic   out_load;
    logic   out_from_mem;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic step_last;
    logic index_ok;
  } dp_status_t;

  // Tempering-free fold used by every recurrence of the seeding.
  function automatic logic [WORD_W-1:0] fold(input logic [WORD_W-1:0] p);
    return p ^ (p >> 30);
  endfunction

endpackage

### rtl/mtseed_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on mtseed_pkg for field widths.
interface mtseed_item_if;
  logic                             valid;
  logic                             ready;
  logic [mtseed_pkg::MODE_W-1:0]    mode;
  logic [mtseed_pkg::WORD_W-1:0]    seed_value;
  logic [mtseed_pkg::ADDR_W-1:0]    word_index;

  modport source (output valid, mode, seed_value, word_index, input ready);
  modport sink   (input valid, mode, seed_value, word_index, output ready);
endinterface

interface mtseed_result_if;
  logic                             valid;
  logic                             ready;
  logic [mtseed_pkg::WORD_W-1:0]    state_word;
  logic                             word_valid;

  modport source (output valid, state_word, word_valid, input ready);
  modport sink   (input valid, state_word, word_valid, output ready);
endinterface

### rtl/mtseed_dp.sv
// Datapath: state table memory, shared multiplier, index counters and result register.
// Driven by mtseed_ctrl through mtseed_pkg::dp_cmd_t; depends on mtseed_pkg.
module mtseed_dp #(
  parameter int TABLE_WORDS = mtseed_pkg::TABLE_WORDS_DEF,
  parameter int KEY_WORDS   = mtseed_pkg::KEY_WORDS_DEF
) (
  input  logic                          clk,
  input  mtseed_pkg::dp_cmd_t           cmd,
  output mtseed_pkg::dp_status_t        status,
  input  mtseed_pkg::key_array_t        key_words,
  input  logic [mtseed_pkg::WORD_W-1:0] seed_value,
  input  logic [mtseed_pkg::ADDR_W-1:0] word_index,
  output logic [mtseed_pkg::WORD_W-1:0] state_word,
  output logic                          word_valid
);

  localparam int W  = mtseed_pkg::WORD_W;
  localparam int AW = mtseed_pkg::ADDR_W;
  localparam int KW = mtseed_pkg::KEY_IDX_W;
  localparam int STEPS_MIX1 = (TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS;
  localparam logic [AW-1:0] LAST_IDX        = AW'(TABLE_WORDS - 1);
  localparam logic [AW-1:0] STEP_LAST_MIX1  = AW'(STEPS_MIX1 - 1);
  localparam logic [AW-1:0] STEP_LAST_MIX2  = AW'(TABLE_WORDS - 2);
  localparam logic [KW-1:0] KEY_LAST        = KW'(KEY_WORDS - 1);
  localparam logic [AW-1:0] TABLE_END       = AW'(TABLE_WORDS);

  logic [W-1:0]  mem [TABLE_WORDS];
  logic [AW-1:0] idx;
  logic [AW-1:0] step;
  logic [KW-1:0] key_idx;
  logic [W-1:0]  p;
  logic [W-1:0]  prod;
  logic [W-1:0]  rdata;

  logic [W-1:0]  mult_c;
  logic [W-1:0]  mult_out;
  logic [W-1:0]  wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  always_comb begin
    case (cmd.phase)
      mtseed_pkg::PH_MIX1: mult_c = mtseed_pkg::MULT_MIX1;
      mtseed_pkg::PH_MIX2: mult_c = mtseed_pkg::MULT_MIX2;
      default:             mult_c = mtseed_pkg::MULT_INIT;
    endcase
  end

  // Only the low word of the product is kept; everything is modulo 2^32.
  assign mult_out = mtseed_pkg::fold(p) * mult_c;

  always_comb begin
    case (cmd.wsrc)
      mtseed_pkg::WSRC_INIT:  wdata = prod + W'(idx);
      mtseed_pkg::WSRC_MIX1:  wdata = (rdata ^ prod) + key_words[key_idx] + W'(key_idx);
      mtseed_pkg::WSRC_MIX2:  wdata = (rdata ^ prod) - W'(idx);
      mtseed_pkg::WSRC_FINAL: wdata = mtseed_pkg::WORD0_FINAL;
      default:                wdata = p;
    endcase
  end

  assign raddr = cmd.rd_ext ? word_index : idx;
  assign waddr = cmd.wr_zero ? '0 : idx;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mult_out;
    end

    if (cmd.p_load_seed) begin
      p <= seed_value;
    end else if (cmd.p_load_key) begin
      p <= mtseed_pkg::SEED_KEY;
    end else if (cmd.p_upd) begin
      p <= wdata;
    end

    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_one) begin
      idx <= AW'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end

    if (cmd.step_clr) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + AW'(1);
    end

    if (cmd.key_clr) begin
      key_idx <= '0;
    end else if (cmd.key_inc) begin
      key_idx <= (key_idx == KEY_LAST) ? '0 : key_idx + KW'(1);
    end

    if (cmd.out_load) begin
      state_word <= cmd.out_from_mem ? rdata : '0;
      word_valid <= cmd.out_from_mem;
    end
  end

  assign status.idx_last  = (idx == LAST_IDX);
  assign status.step_last = (cmd.phase == mtseed_pkg::PH_MIX1) ? (step == STEP_LAST_MIX1)
                                                               : (step == STEP_LAST_MIX2);
  assign status.index_ok  = (word_index < TABLE_END);

endmodule

### rtl/mtseed_ctrl.sv
// Controller: sequences seeding passes and reads, owns both handshakes.
// Commands mtseed_dp through mtseed_pkg::dp_cmd_t; depends on mtseed_pkg.
module mtseed_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [mtseed_pkg::MODE_W-1:0] item_mode,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mtseed_pkg::dp_cmd_t           cmd,
  input  mtseed_pkg::dp_status_t        status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_W0,
    S_INIT_MUL,
    S_INIT_WR,
    S_MIX_RD,
    S_MIX_WR,
    S_MIX_COPY,
    S_FINAL
  } state_t;

  state_t              state, state_next;
  logic                resp_pending, resp_pending_next;
  mtseed_pkg::phase_t  phase, phase_next;
  logic                key_mode, key_mode_next;
  logic                pass_done, pass_done_next;
  logic                from_mem, from_mem_next;
  logic                seeded, seeded_next;
  logic                result_valid_next;
  logic                accept;
  logic                slot_free;

  assign item_ready = (state == S_IDLE) && !resp_pending;
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;

  always_comb begin
    state_next        = state;
    resp_pending_next = resp_pending;
    phase_next        = phase;
    key_mode_next     = key_mode;
    pass_done_next    = pass_done;
    from_mem_next     = from_mem;
    seeded_next       = seeded;
    result_valid_next = result_valid && !result_ready;
    cmd               = '0;
    cmd.phase         = phase;
    cmd.wsrc          = mtseed_pkg::WSRC_P;

    // A finished result moves into the output register once it is free.
    if (resp_pending && slot_free) begin
      cmd.out_load      = 1'b1;
      cmd.out_from_mem  = from_mem;
      result_valid_next = 1'b1;
      resp_pending_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mtseed_pkg::mode_t'(item_mode))
            mtseed_pkg::MODE_SEED_VALUE: begin
              cmd.p_load_seed = 1'b1;
              cmd.idx_zero    = 1'b1;
              key_mode_next   = 1'b0;
              state_next      = S_INIT_W0;
            end
            mtseed_pkg::MODE_SEED_KEY: begin
              cmd.p_load_key = 1'b1;
              cmd.idx_zero   = 1'b1;
              key_mode_next  = 1'b1;
              state_next     = S_INIT_W0;
            end
            mtseed_pkg::MODE_READ: begin
              cmd.rd_en         = 1'b1;
              cmd.rd_ext        = 1'b1;
              from_mem_next     = seeded && status.index_ok;
              resp_pending_next = 1'b1;
            end
            default: begin
              from_mem_next     = 1'b0;
              resp_pending_next = 1'b1;
            end
          endcase
        end
      end
      S_INIT_W0: begin
        cmd.wr_en   = 1'b1;
        cmd.wsrc    = mtseed_pkg::WSRC_P;
        cmd.idx_inc = 1'b1;
        state_next  = S_INIT_MUL;
      end
      S_INIT_MUL: begin
        cmd.phase  = mtseed_pkg::PH_INIT;
        cmd.mul_en = 1'b1;
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.phase = mtseed_pkg::PH_INIT;
        cmd.wr_en = 1'b1;
        cmd.wsrc  = mtseed_pkg::WSRC_INIT;
        cmd.p_upd = 1'b1;
        if (!status.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_INIT_MUL;
        end else if (key_mode) begin
          // Mixing starts at word 1 with word 0 (the key seed) as predecessor.
          cmd.p_load_key = 1'b1;
          cmd.idx_one    = 1'b1;
          cmd.step_clr   = 1'b1;
          cmd.key_clr    = 1'b1;
          phase_next     = mtseed_pkg::PH_MIX1;
          state_next     = S_MIX_RD;
        end else begin
          seeded_next       = 1'b1;
          from_mem_next     = 1'b0;
          resp_pending_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_MIX_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.mul_en = 1'b1;
        state_next = S_MIX_WR;
      end
      S_MIX_WR: begin
        cmd.wr_en      = 1'b1;
        cmd.wsrc       = (phase == mtseed_pkg::PH_MIX1) ? mtseed_pkg::WSRC_MIX1
                                                        : mtseed_pkg::WSRC_MIX2;
        cmd.p_upd      = 1'b1;
        cmd.step_inc   = 1'b1;
        cmd.key_inc    = (phase == mtseed_pkg::PH_MIX1);
        pass_done_next = status.step_last;
        if (status.idx_last) begin
          state_next = S_MIX_COPY;
        end else begin
          cmd.idx_inc = 1'b1;
          if (status.step_last) begin
            if (phase == mtseed_pkg::PH_MIX1) begin
              cmd.step_clr = 1'b1;
              phase_next   = mtseed_pkg::PH_MIX2;
              state_next   = S_MIX_RD;
            end else begin
              state_next = S_FINAL;
            end
          end else begin
            state_next = S_MIX_RD;
          end
        end
      end
      S_MIX_COPY: begin
        // The last word is mirrored into word 0, then the walk wraps to word 1.
        cmd.wr_en   = 1'b1;
        cmd.wr_zero = 1'b1;
        cmd.wsrc    = mtseed_pkg::WSRC_P;
        cmd.idx_one = 1'b1;
        if (pass_done) begin
          if (phase == mtseed_pkg::PH_MIX1) begin
            cmd.step_clr = 1'b1;
            phase_next   = mtseed_pkg::PH_MIX2;
            state_next   = S_MIX_RD;
          end else begin
            state_next = S_FINAL;
          end
        end else begin
          state_next = S_MIX_RD;
        end
      end
      S_FINAL: begin
        cmd.wr_en         = 1'b1;
        cmd.wr_zero       = 1'b1;
        cmd.wsrc          = mtseed_pkg::WSRC_FINAL;
        seeded_next       = 1'b1;
        from_mem_next     = 1'b0;
        resp_pending_next = 1'b1;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      resp_pending <= 1'b0;
      phase        <= mtseed_pkg::PH_INIT;
      key_mode     <= 1'b0;
      pass_done    <= 1'b0;
      from_mem     <= 1'b0;
      seeded       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      resp_pending <= resp_pending_next;
      phase        <= phase_next;
      key_mode     <= key_mode_next;
      pass_done    <= pass_done_next;
      from_mem     <= from_mem_next;
      seeded       <= seeded_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

### rtl/mt19937_state_seeding.sv
// Top level of the MT19937 state seeding block: key registers, controller and datapath.
// Depends on mtseed_pkg, mtseed_if, mtseed_ctrl and mtseed_dp.
//
//   Channel  Kind             Transaction fields
//   item     valid/ready in   mode, seed_value, word_index
//   result   valid/ready out  state_word, word_valid
//   cfg      write only       cfg_wr_en, cfg_index, cfg_data (key_word_0..3)
//
// Each item gives exactly one result transaction, in order.
// A read (mode 2) or a no-op (mode 3) is taken in the controller's idle state; a read's
// word comes out of the registered memory port, then is loaded into the output register.
// Seeding from a value does one word write, then a multiply step and a write step
// per word, since the recurrence runs through the one shared multiplier and the
// single write port of the 624-word state table.
// Seeding from the key array does the same fill, then two mixing walks in which each
// word is read and multiplied in S_MIX_RD and written in S_MIX_WR, with an extra
// copy into word 0 per wrap, and a final write in S_FINAL that forces word 0.
// Reset (rst, synchronous) clears control state, the seeded flag and the key
// registers; the table holds no defined value until a seeding has filled it.
// A stalled result waits in the output register; the next item is taken while it
// waits, and that item's result is held back until the register frees up.
module mt19937_state_seeding #(
  parameter int TABLE_WORDS = mtseed_pkg::TABLE_WORDS_DEF,
  parameter int KEY_WORDS   = mtseed_pkg::KEY_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  mtseed_item_if.sink                      item,
  mtseed_result_if.source                  result,
  input  logic                             cfg_wr_en,
  input  logic [mtseed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtseed_pkg::WORD_W-1:0]    cfg_data
);

  mtseed_pkg::key_array_t key_words;
  mtseed_pkg::dp_cmd_t    cmd;
  mtseed_pkg::dp_status_t status;

  // The four key registers; the index decodes straight onto the register array.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_words <= '0;
    end else if (cfg_wr_en) begin
      key_words[cfg_index] <= cfg_data;
    end
  end

  mtseed_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_mode    (item.mode),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .status       (status)
  );

  mtseed_dp #(
    .TABLE_WORDS (TABLE_WORDS),
    .KEY_WORDS   (KEY_WORDS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .key_words  (key_words),
    .seed_value (item.seed_value),
    .word_index (item.word_index),
    .state_word (result.state_word),
    .word_valid (result.word_valid)
  );

endmodule

### rtl/mtseed_checker.sv
// Port-level checker for mt19937_state_seeding, attached with a bind statement.
// Depends on mtseed_pkg for field widths and mode codes.
module mtseed_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [mtseed_pkg::MODE_W-1:0] item_mode,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [mtseed_pkg::WORD_W-1:0] state_word,
  input logic                          word_valid
);

  logic [1:0] pending;
  logic       seen_seed;
  logic       item_acc;
  logic       result_acc;

  assign item_acc   = item_valid && item_ready;
  assign result_acc = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      seen_seed <= 1'b0;
    end else begin
      pending <= pending + {1'b0, item_acc} - {1'b0, result_acc};
      if (item_acc && (item_mode == mtseed_pkg::MODE_SEED_VALUE ||
                       item_mode == mtseed_pkg::MODE_SEED_KEY)) begin
        seen_seed <= 1'b1;
      end
    end
  end

  // At most one result in the output register and one item at work.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two transactions outstanding");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result offered with no item outstanding");

  a_valid_needs_seed: assert property (@(posedge clk) disable iff (rst)
    (result_valid && word_valid) |-> seen_seed)
    else $error("valid state word before any seeding");

  a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !word_valid) |-> state_word == '0)
    else $error("nonzero state word with word_valid low");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(state_word)))
    else $error("stalled result changed");

endmodule

bind mt19937_state_seeding mtseed_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_mode    (item.mode),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .state_word   (result.state_word),
  .word_valid   (result.word_valid)
);
